[hw/rtl/wavhp_pkg.sv]
package wavhp_pkg;

    // Header scan window in bytes; the data size field must end inside it.
    localparam int unsigned HEADER_WINDOW = 512;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] PLAIN_FMT_LEN = 32'h0000_0010;
    localparam logic [15:0] NO_EXTRA      = 16'h0000;
    localparam logic [15:0] PCM_FORMAT    = 16'd1;
    localparam logic [15:0] PCM_BITS      = 16'd16;
    localparam logic [9:0]  BASE_DATA_POS = 10'd36;

    typedef enum logic [3:0] {
        ST_VALID        = 4'd0,
        ST_RIFF         = 4'd1,
        ST_WAVE         = 4'd2,
        ST_FMT_ID       = 4'd3,
        ST_FORMAT_TAG   = 4'd4,
        ST_BITS         = 4'd5,
        ST_EXTRA_BYTES  = 4'd6,
        ST_FACT_ID      = 4'd7,
        ST_DATA_ID      = 4'd8,
        ST_TOO_LONG     = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] riff_size;
        logic [15:0] num_channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] audio_data_size;
        logic [9:0]  audio_data_offset;
    } t_out_item;

    // Handshake between the input stage and the parse stage.
    typedef struct packed {
        logic valid;
        logic go;
    } t_stage_ctl;

endpackage

[hw/rtl/wavhp_in_reg.sv]
module wavhp_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wavhp_pkg::t_in_item i_in_item,
    input  logic                i_go,
    output wavhp_pkg::t_stage_ctl o_ctl,
    output wavhp_pkg::t_in_item o_item
);

    logic                r_valid;
    logic                n_valid;
    wavhp_pkg::t_in_item r_item;
    logic                accept;

    // Held item blocks a new one only when the parse stage cannot take it.
    assign o_in_stall = r_valid && !i_go;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item <= i_in_item;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.go    = i_go;
    assign o_item      = r_item;

endmodule

[hw/rtl/wavhp_parse.sv]
module wavhp_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wavhp_pkg::t_stage_ctl i_ctl,
    input  wavhp_pkg::t_in_item   i_item,
    output logic                  o_emit,
    output wavhp_pkg::t_out_item  o_result
);

    logic [9:0]  r_pos,   c_pos,   n_pos;
    logic [31:0] r_ws,    c_ws,    n_ws;
    logic        r_extra, c_extra, n_extra;
    logic [9:0]  r_dtp,   c_dtp,   n_dtp;
    logic        r_done,  c_done,  n_done;
    logic [31:0] r_riff,  c_riff,  n_riff;
    logic [15:0] r_chan,  c_chan,  n_chan;
    logic [31:0] r_rate,  c_rate,  n_rate;
    logic [31:0] r_brate, c_brate, n_brate;
    logic [15:0] r_align, c_align, n_align;

    logic [31:0] ws_new;
    logic [15:0] half;
    logic [9:0]  dtp_p3;
    logic [9:0]  dtp_p7;
    logic [33:0] fact_end;
    logic        too_long;
    logic        emit;
    wavhp_pkg::t_status st;
    logic [15:0] bits;
    logic [31:0] size;
    logic [9:0]  offset;
    logic        upd;

    // Start of file behaves as if the state had just been cleared.
    always_comb begin
        c_pos   = i_item.start_of_file ? 10'd0 : r_pos;
        c_ws    = i_item.start_of_file ? 32'd0 : r_ws;
        c_extra = i_item.start_of_file ? 1'b0  : r_extra;
        c_dtp   = i_item.start_of_file ? wavhp_pkg::BASE_DATA_POS : r_dtp;
        c_done  = i_item.start_of_file ? 1'b0  : r_done;
        c_riff  = i_item.start_of_file ? 32'd0 : r_riff;
        c_chan  = i_item.start_of_file ? 16'd0 : r_chan;
        c_rate  = i_item.start_of_file ? 32'd0 : r_rate;
        c_brate = i_item.start_of_file ? 32'd0 : r_brate;
        c_align = i_item.start_of_file ? 16'd0 : r_align;
    end

    assign ws_new   = {i_item.data_byte, c_ws[31:8]};
    assign half     = ws_new[31:16];
    assign dtp_p3   = c_dtp + 10'd3;
    assign dtp_p7   = c_dtp + 10'd7;
    assign fact_end = {2'b00, ws_new} + 34'd54;
    assign too_long = fact_end > 34'(wavhp_pkg::HEADER_WINDOW);

    always_comb begin
        n_pos   = c_pos;
        n_ws    = c_ws;
        n_extra = c_extra;
        n_dtp   = c_dtp;
        n_riff  = c_riff;
        n_chan  = c_chan;
        n_rate  = c_rate;
        n_brate = c_brate;
        n_align = c_align;
        emit    = 1'b0;
        st      = wavhp_pkg::ST_VALID;
        bits    = wavhp_pkg::PCM_BITS;
        size    = 32'd0;
        offset  = 10'd0;
        if (!c_done) begin
            n_ws  = ws_new;
            n_pos = c_pos + 10'd1;
            if (c_pos < wavhp_pkg::BASE_DATA_POS) begin
                case (c_pos)
                    10'd3: begin
                        if (ws_new != wavhp_pkg::TAG_RIFF) begin
                            emit = 1'b1; st = wavhp_pkg::ST_RIFF; bits = 16'd0;
                        end
                    end
                    10'd7:  n_riff = ws_new;
                    10'd11: begin
                        if (ws_new != wavhp_pkg::TAG_WAVE) begin
                            emit = 1'b1; st = wavhp_pkg::ST_WAVE; bits = 16'd0;
                        end
                    end
                    10'd15: begin
                        if (ws_new != wavhp_pkg::TAG_FMT) begin
                            emit = 1'b1; st = wavhp_pkg::ST_FMT_ID; bits = 16'd0;
                        end
                    end
                    10'd19: n_extra = (ws_new != wavhp_pkg::PLAIN_FMT_LEN);
                    10'd21: begin
                        if (half != wavhp_pkg::PCM_FORMAT) begin
                            emit = 1'b1; st = wavhp_pkg::ST_FORMAT_TAG; bits = 16'd0;
                        end
                    end
                    10'd23: n_chan  = half;
                    10'd27: n_rate  = ws_new;
                    10'd31: n_brate = ws_new;
                    10'd33: n_align = half;
                    10'd35: begin
                        if (half != wavhp_pkg::PCM_BITS) begin
                            emit = 1'b1; st = wavhp_pkg::ST_BITS; bits = half;
                        end
                    end
                    default: ;
                endcase
            end else if (c_extra && c_pos <= 10'd45) begin
                if (c_pos == 10'd37 && half != wavhp_pkg::NO_EXTRA) begin
                    emit = 1'b1; st = wavhp_pkg::ST_EXTRA_BYTES;
                end else if (c_pos == 10'd41 && ws_new != wavhp_pkg::TAG_FACT) begin
                    emit = 1'b1; st = wavhp_pkg::ST_FACT_ID;
                end else if (c_pos == 10'd45) begin
                    if (too_long) begin
                        emit = 1'b1; st = wavhp_pkg::ST_TOO_LONG;
                    end else begin
                        // fits: fact length is below the window here
                        n_dtp = ws_new[9:0] + 10'd46;
                    end
                end
            end else if (c_pos == dtp_p3 && ws_new != wavhp_pkg::TAG_DATA) begin
                emit = 1'b1; st = wavhp_pkg::ST_DATA_ID;
            end else if (c_pos == dtp_p7) begin
                emit   = 1'b1;
                st     = wavhp_pkg::ST_VALID;
                size   = ws_new;
                offset = c_dtp + 10'd8;
            end
        end
        n_done = c_done | emit;
    end

    assign upd = i_ctl.valid && i_ctl.go && (i_item.start_of_file || !r_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 10'd0;
            r_ws    <= 32'd0;
            r_extra <= 1'b0;
            r_dtp   <= wavhp_pkg::BASE_DATA_POS;
            r_done  <= 1'b1;
            r_riff  <= 32'd0;
            r_chan  <= 16'd0;
            r_rate  <= 32'd0;
            r_brate <= 32'd0;
            r_align <= 16'd0;
        end else if (upd) begin
            r_pos   <= n_pos;
            r_ws    <= n_ws;
            r_extra <= n_extra;
            r_dtp   <= n_dtp;
            r_done  <= n_done;
            r_riff  <= n_riff;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_brate <= n_brate;
            r_align <= n_align;
        end
    end

    assign o_emit = i_ctl.valid && emit;

    always_comb begin
        o_result.status            = st;
        o_result.riff_size         = c_riff;
        o_result.num_channels      = c_chan;
        o_result.sample_rate       = c_rate;
        o_result.byte_rate         = c_brate;
        o_result.block_align       = c_align;
        o_result.bits_per_sample   = bits;
        o_result.audio_data_size   = size;
        o_result.audio_data_offset = offset;
    end

endmodule

[hw/rtl/wavhp_out_reg.sv]
module wavhp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  wavhp_pkg::t_out_item i_result,
    output logic                 o_free,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wavhp_pkg::t_out_item o_out_item
);

    logic                 r_valid;
    logic                 n_valid;
    wavhp_pkg::t_out_item r_item;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

[hw/rtl/wav_header_parser_unit.sv]
// WAV (RIFF/PCM) header parser.
// Input channel: one file byte per item (i_in_item.data_byte); start_of_file
// marks byte 0 of a new file and restarts parsing. Bytes before the first
// start, and bytes after a file's result, are swallowed without a result.
// Output channel: at most one item per file, carrying a status code, the
// captured format fields, the data chunk size and the offset of the first
// sample byte. It appears after the last data-size byte, or after the first
// bad byte, and o_out_valid rises once it sits in the result register.
// Bytes are parsed from the input register. Throughput: one byte per cycle
// while o_in_stall is low. Parse state (position, shift word, held
// fields) updates in the same cycle the byte leaves the input register.
// Only a byte that produces a result needs the result register free; others
// pass even while the receiver stalls. When a result waits under i_out_stall
// and the next byte would also produce one, that byte waits in the input
// register and o_in_stall rises until the output drains.
// Reset (synchronous, active low) empties both registers and leaves the
// parser idle until a start_of_file byte.
module wav_header_parser_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  wavhp_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output wavhp_pkg::t_out_item o_out_item
);

    wavhp_pkg::t_stage_ctl ctl;
    wavhp_pkg::t_in_item   item;
    wavhp_pkg::t_out_item  result;
    logic                  emit;
    logic                  out_free;
    logic                  go;

    // The held byte moves on unless it makes a result while the output is full and stalled.
    assign go = !emit || out_free;

    wavhp_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_go       (go),
        .o_ctl      (ctl),
        .o_item     (item)
    );

    wavhp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (item),
        .o_emit   (emit),
        .o_result (result)
    );

    wavhp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit && out_free),
        .i_result    (result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[hw/rtl/wavhp_checker.sv]
module wavhp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input wavhp_pkg::t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= wavhp_pkg::ST_TOO_LONG)
        else $error("status code out of range");

    a_good_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == wavhp_pkg::ST_VALID |->
            o_out_item.bits_per_sample == wavhp_pkg::PCM_BITS &&
            (o_out_item.audio_data_offset >= 10'd44 ||
             o_out_item.audio_data_offset == 10'd0))
        else $error("good header with bad bits or offset");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != wavhp_pkg::ST_VALID |->
            o_out_item.audio_data_size == 32'd0 &&
            o_out_item.audio_data_offset == 10'd0)
        else $error("error result carries data size or offset");

endmodule

bind wav_header_parser_unit wavhp_checker u_wavhp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[tb/sv/wav_header_checker.sv]
module wav_header_checker
    import wavhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results_seen,
    output logic [9:0] o_status_seen
);

    localparam logic [9:0]  FACT_LEN_END  = 10'd45;
    localparam logic [31:0] FACT_DATA_POS = 32'd46;
    localparam logic [33:0] HEADER_TAIL   = 34'd54;

    // Parser shadow state
    logic [9:0]  byte_pos;
    logic [31:0] last_word;
    logic        fmt_extended;
    logic [31:0] fact_len;
    logic [9:0]  data_tag_pos;
    logic        header_done;
    logic [31:0] riff_size_h;
    logic [15:0] channels_h;
    logic [31:0] sample_rate_h;
    logic [31:0] byte_rate_h;
    logic [15:0] block_align_h;

    t_out_item   header_results_q[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
        o_status_seen  = '0;
    end

    task automatic clear_header();
        byte_pos      = '0;
        last_word     = '0;
        fmt_extended  = 1'b0;
        fact_len      = '0;
        data_tag_pos  = BASE_DATA_POS;
        riff_size_h   = '0;
        channels_h    = '0;
        sample_rate_h = '0;
        byte_rate_h   = '0;
        block_align_h = '0;
    endtask

    function automatic t_out_item header_result(t_status st, logic [15:0] bits,
                                                logic [31:0] size, logic [9:0] offset);
        t_out_item r;
        r.status            = st;
        r.riff_size         = riff_size_h;
        r.num_channels      = channels_h;
        r.sample_rate       = sample_rate_h;
        r.byte_rate         = byte_rate_h;
        r.block_align       = block_align_h;
        r.bits_per_sample   = bits;
        r.audio_data_size   = size;
        r.audio_data_offset = offset;
        return r;
    endfunction

    task automatic parse_byte(input t_in_item item);
        logic [9:0]  p;
        logic [15:0] upper;
        logic [33:0] data_end;
        logic [31:0] tag_at;
        logic        hit;
        t_out_item   r;
        hit = 1'b0;
        r   = '0;
        if (item.start_of_file) begin
            clear_header();
            header_done = 1'b0;
        end
        if (!header_done) begin
            last_word = {item.data_byte, last_word[31:8]};
            upper     = last_word[31:16];
            p         = byte_pos;
            byte_pos  = byte_pos + 10'd1;
            if (p < BASE_DATA_POS) begin
                case (p)
                    10'd3: if (last_word != TAG_RIFF) begin
                        r = header_result(ST_RIFF, '0, '0, '0); hit = 1'b1;
                    end
                    10'd7: riff_size_h = last_word;
                    10'd11: if (last_word != TAG_WAVE) begin
                        r = header_result(ST_WAVE, '0, '0, '0); hit = 1'b1;
                    end
                    10'd15: if (last_word != TAG_FMT) begin
                        r = header_result(ST_FMT_ID, '0, '0, '0); hit = 1'b1;
                    end
                    10'd19: fmt_extended = (last_word != PLAIN_FMT_LEN);
                    10'd21: if (upper != PCM_FORMAT) begin
                        r = header_result(ST_FORMAT_TAG, '0, '0, '0); hit = 1'b1;
                    end
                    10'd23: channels_h = upper;
                    10'd27: sample_rate_h = last_word;
                    10'd31: byte_rate_h = last_word;
                    10'd33: block_align_h = upper;
                    10'd35: if (upper != PCM_BITS) begin
                        r = header_result(ST_BITS, upper, '0, '0); hit = 1'b1;
                    end
                    default: ;
                endcase
            end else if (fmt_extended && p <= FACT_LEN_END) begin
                if (p == 10'd37 && upper != NO_EXTRA) begin
                    r = header_result(ST_EXTRA_BYTES, PCM_BITS, '0, '0); hit = 1'b1;
                end else if (p == 10'd41 && last_word != TAG_FACT) begin
                    r = header_result(ST_FACT_ID, PCM_BITS, '0, '0); hit = 1'b1;
                end else if (p == FACT_LEN_END) begin
                    fact_len = last_word;
                    data_end = {2'b00, fact_len} + HEADER_TAIL;
                    if (data_end > HEADER_WINDOW) begin
                        r = header_result(ST_TOO_LONG, PCM_BITS, '0, '0); hit = 1'b1;
                    end else begin
                        tag_at       = fact_len + FACT_DATA_POS;
                        data_tag_pos = tag_at[9:0];
                    end
                end
            end else if (p == data_tag_pos + 10'd3 && last_word != TAG_DATA) begin
                r = header_result(ST_DATA_ID, PCM_BITS, '0, '0); hit = 1'b1;
            end else if (p == data_tag_pos + 10'd7) begin
                r = header_result(ST_VALID, PCM_BITS, last_word, data_tag_pos + 10'd8);
                hit = 1'b1;
            end
            if (hit) begin
                header_done = 1'b1;
                header_results_q.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("MISMATCH result %0d: %s", o_results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (header_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item, status %0d", got.status));
        end else begin
            want = header_results_q.pop_front();
            o_status_seen[want.status] = 1'b1;
            compare_field("status", {28'd0, got.status}, {28'd0, want.status});
            compare_field("riff_size", got.riff_size, want.riff_size);
            compare_field("num_channels", {16'd0, got.num_channels},
                          {16'd0, want.num_channels});
            compare_field("sample_rate", got.sample_rate, want.sample_rate);
            compare_field("byte_rate", got.byte_rate, want.byte_rate);
            compare_field("block_align", {16'd0, got.block_align},
                          {16'd0, want.block_align});
            compare_field("bits_per_sample", {16'd0, got.bits_per_sample},
                          {16'd0, want.bits_per_sample});
            compare_field("audio_data_size", got.audio_data_size, want.audio_data_size);
            compare_field("audio_data_offset", {22'd0, got.audio_data_offset},
                          {22'd0, want.audio_data_offset});
        end
        o_results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_header();
            header_done = 1'b1;
            header_results_q.delete();
        end else begin
            if (i_out_valid === 1'b1 && i_out_stall == 1'b0)
                check_result(i_out_item);
            if (i_in_valid == 1'b1 && i_in_stall === 1'b0)
                parse_byte(i_in_item);
        end
        o_pending = header_results_q.size();
    end

endmodule

[tb/sv/tb_wav_header_parser_unit.sv]
// Stimulus and verdict for the WAV header parser. The checker beside the DUT
// watches both channels, predicts every result and counts mismatches; this
// module only builds byte streams, paces both sides and decides the outcome.
module tb_wav_header_parser_unit;
    import wavhp_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    localparam int IDLE_PCT     = 9;      // idle chance per cycle, each side
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;   // cycles with no item moving
    localparam int DRAIN_CYCLES = 10;
    localparam int RESET_CYCLES = 10;
    localparam int PRESS_FILES  = 20;
    // Longest fact chunk that still lets the data size end inside the window.
    localparam int MAX_FACT_LEN = HEADER_WINDOW - 54;

    // Shapes of generated files. The error kinds each break one field.
    typedef enum int {
        F_PLAIN,
        F_EXTENDED,
        F_BAD_RIFF,
        F_BAD_WAVE,
        F_BAD_FMT,
        F_BAD_FORMAT,
        F_BAD_BITS,
        F_BAD_EXTRA,
        F_BAD_FACT,
        F_BAD_DATA,
        F_TOO_LONG,
        F_CUT_SHORT,
        F_NOISE,
        F_KIND_COUNT
    } t_file_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;

    int         fail_count;
    int         pending;
    int         results_seen;
    logic [9:0] status_seen;

    logic       quiet;        // no idling on either side while set
    logic       hold_req;     // asks the receiver for a long hold-off
    int         hold_left;
    int         quiet_cycles;
    int         bytes_sent;
    int         files_sent;
    int         file_no;
    t_file_kind kind;
    logic [7:0] file_q[$];    // bytes of the file being sent

    wav_header_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    wav_header_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_item     (o_out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_status_seen  (status_seen)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver: random stall, or a long counted hold-off on request. Driven on
    // the falling edge so the DUT sees a settled stall at the rising edge.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: any item moving on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it, and hold it until
    // the DUT takes it. Valid stays high on return so back-to-back bytes
    // need no extra edge; callers lower it before letting time pass.
    task automatic send_byte(input logic [7:0] value, input logic sof);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid                = 1'b1;
        i_in_item.data_byte       = value;
        i_in_item.start_of_file   = sof;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // with_start marks the first byte; scatter_starts drops random restarts
    // into noise so that garbage files get parsed too.
    task automatic send_file(input logic with_start, input logic scatter_starts);
        logic sof;
        for (int k = 0; k < file_q.size(); k++) begin
            sof = (with_start && k == 0) ||
                  (scatter_starts && $urandom_range(5) == 0);
            send_byte(file_q[k], sof);
        end
        files_sent++;
    endtask

    task automatic put_le(input logic [31:0] value, input int nbytes);
        for (int k = 0; k < nbytes; k++)
            file_q.push_back(value[8*k +: 8]);
    endtask

    task automatic trim_to(input int len);
        while (file_q.size() > len)
            void'(file_q.pop_back());
    endtask

    // Break one byte of a field, then drop most of what follows: bytes past
    // the error are ignored by the parser anyway.
    task automatic fault_field(input int first, input int span);
        int         idx;
        logic [7:0] flip;
        idx          = first + $urandom_range(span - 1);
        flip         = 8'($urandom_range(255, 1));
        file_q[idx]  = file_q[idx] ^ flip;
        trim_to(first + span + $urandom_range(2));
    endtask

    function automatic logic [31:0] pick_fact_len(input logic over, input logic longest);
        int          r;
        logic [31:0] v;
        r = $urandom_range(99);
        if (longest)
            return MAX_FACT_LEN;
        if (!over) begin
            if (r < 85)
                return $urandom_range(12);
            if (r < 97)
                return $urandom_range(100, 13);
            return MAX_FACT_LEN;
        end
        // Just past the window, moderately past, or anything up to all ones
        // (the length check must not wrap).
        if (r < 50)
            return MAX_FACT_LEN + 1;
        if (r < 75)
            return $urandom_range(2000, MAX_FACT_LEN + 2);
        v = $urandom;
        return (v <= MAX_FACT_LEN) ? 32'hFFFF_FFFF : v;
    endfunction

    function automatic t_file_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 18)
            return F_PLAIN;
        if (r < 36)
            return F_EXTENDED;
        if (r < 90)
            return t_file_kind'(int'(F_BAD_RIFF) + (r - 36) / 6);
        if (r < 95)
            return F_CUT_SHORT;
        return F_NOISE;
    endfunction

    // Build a whole header of the given kind into file_q (F_NOISE: one to eight
    // random bytes): tags, fixed fields correct, rest random, kind's damage applied.
    task automatic build_file(input t_file_kind fk, input logic longest);
        logic        extended;
        logic [31:0] fmt_len;
        logic [31:0] fact_size;
        int          data_at;
        file_q.delete();
        if (fk == F_NOISE) begin
            repeat ($urandom_range(8, 1))
                file_q.push_back(8'($urandom));
        end else begin
            extended = (fk == F_EXTENDED) || (fk == F_BAD_EXTRA) ||
                       (fk == F_BAD_FACT) || (fk == F_TOO_LONG) ||
                       ((fk == F_BAD_DATA || fk == F_CUT_SHORT) && $urandom_range(1) == 1);
            put_le(TAG_RIFF, 4);
            put_le($urandom, 4);
            put_le(TAG_WAVE, 4);
            put_le(TAG_FMT, 4);
            fmt_len = PLAIN_FMT_LEN;
            if (extended) begin
                fmt_len = ($urandom_range(1) == 1) ? 32'd18 : $urandom;
                if (fmt_len == PLAIN_FMT_LEN)
                    fmt_len = 32'd20;
            end
            put_le(fmt_len, 4);
            put_le({16'd0, PCM_FORMAT}, 2);
            put_le($urandom, 2);              // channels
            put_le($urandom, 4);              // sample rate
            put_le($urandom, 4);              // byte rate
            put_le($urandom, 2);              // block align
            put_le({16'd0, PCM_BITS}, 2);
            data_at = BASE_DATA_POS;
            if (extended) begin
                put_le({16'd0, NO_EXTRA}, 2);
                put_le(TAG_FACT, 4);
                fact_size = pick_fact_len(fk == F_TOO_LONG, longest);
                put_le(fact_size, 4);
                if (fact_size <= MAX_FACT_LEN) begin
                    repeat (fact_size)
                        file_q.push_back(8'($urandom));
                    data_at = 46 + int'(fact_size);
                end
            end
            put_le(TAG_DATA, 4);
            put_le($urandom, 4);
            repeat ($urandom_range(3))
                file_q.push_back(8'($urandom));
            case (fk)
                F_BAD_RIFF:   fault_field(0, 4);
                F_BAD_WAVE:   fault_field(8, 4);
                F_BAD_FMT:    fault_field(12, 4);
                F_BAD_FORMAT: fault_field(20, 2);
                F_BAD_BITS:   fault_field(34, 2);
                F_BAD_EXTRA:  fault_field(36, 2);
                F_BAD_FACT:   fault_field(38, 4);
                F_BAD_DATA:   fault_field(data_at, 4);
                F_TOO_LONG:   trim_to(46 + $urandom_range(2));
                F_CUT_SHORT:  trim_to($urandom_range(file_q.size() - 1, 1));
                default: ;
            endcase
        end
    endtask

    // Let every predicted result drain before offering more bytes.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        bytes_sent  = 0;
        files_sent  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: bytes before any start are ignored.
        file_q = '{8'h00, 8'hFF, 8'h52};
        send_file(1'b0, 1'b0);
        // Bad last byte of the RIFF tag: error with nothing captured.
        file_q.delete();
        put_le(TAG_RIFF ^ 32'hFF00_0000, 4);
        send_file(1'b1, 1'b0);
        // A file cut off mid-header, restarted by the next start.
        file_q.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'h0000_0000, 4);
        send_file(1'b1, 1'b0);
        // WAVE tag broken after an all-ones RIFF size; trailing bytes ignored.
        file_q.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(TAG_WAVE ^ 32'h0000_0001, 4);
        file_q.push_back(8'hFF);
        file_q.push_back(8'h00);
        send_file(1'b1, 1'b0);

        // Random part. The first pass walks every kind once (the extended
        // one with the longest fact chunk the window allows), then kinds are
        // drawn with well-formed files and single-field faults dominating.
        file_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            quiet = (file_no >= 16 && file_no < 26);
            if (file_no == F_KIND_COUNT) begin
                // Receiver holds off while short faulty files keep coming:
                // the result register fills and the input side must stall.
                hold_req = 1'b1;
                repeat (PRESS_FILES) begin
                    build_file(F_BAD_RIFF, 1'b0);
                    send_file(1'b1, 1'b0);
                end
            end
            if (file_no > F_KIND_COUNT && file_no % 7 == 0) begin
                wait_drained();
                repeat ($urandom_range(6, 1)) @(negedge i_clk);
            end
            kind = (file_no < F_KIND_COUNT) ? t_file_kind'(file_no) : pick_kind();
            build_file(kind, file_no == F_EXTENDED);
            send_file(kind != F_NOISE, kind == F_NOISE);
            file_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d bytes in %0d files; %0d header results compared.",
                 bytes_sent, files_sent, results_seen);
        $display("Status codes reported (bit per code, 9 down to 0): %b", status_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wavhp_pkg.sv
hw/rtl/wavhp_in_reg.sv
hw/rtl/wavhp_parse.sv
hw/rtl/wavhp_out_reg.sv
hw/rtl/wav_header_parser_unit.sv
hw/rtl/wavhp_checker.sv
tb/sv/wav_header_checker.sv
tb/sv/tb_wav_header_parser_unit.sv
